// ----- hdl/u8ns_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8ns_pkg: shared types and constants for the utf-8 name sanitizer
// Word layouts of both channels, the run descriptor passed from front to back,
// and the byte-class constants.
// ----------------------------------------------------------------------------
package u8ns_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [6:0] QMARK       = 7'h3F;
  localparam logic [7:0] PRINT_LO    = 8'h20;
  localparam logic [7:0] PRINT_HI    = 8'h7F;
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_VAL    = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_VAL   = 8'hC0;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_VAL   = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_VAL   = 8'hF0;
  localparam logic [7:0] LEAD4_MAX   = 8'hF4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       name_last;
  } in_word_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       run_last;
    logic       name_end;
  } out_word_t;

  // one input byte's results: cnt words, all '?' but the last, which is chr
  typedef struct packed {
    logic [2:0] cnt;
    logic [6:0] chr;
    logic       name_end;
  } run_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if ((b & LEAD2_MASK) == LEAD2_VAL && b >= LEAD2_MIN) begin
      len = 3'd2;
    end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
      len = 3'd3;
    end else if ((b & LEAD4_MASK) == LEAD4_VAL && b <= LEAD4_MAX) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

// ----- hdl/u8ns_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8ns_front: byte classifier
// Tracks the open utf-8 sequence and turns each accepted byte that yields
// output into a run descriptor for the back end.
// ----------------------------------------------------------------------------
module u8ns_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  u8ns_pkg::in_word_t in_data,
  output logic               run_valid,
  output u8ns_pkg::run_t     run
);

  logic [1:0] held_r, held_nxt;
  logic [2:0] exp_r, exp_nxt;
  logic [2:0] h;
  logic [2:0] n;
  logic [2:0] len;
  logic [6:0] chr;
  logic       fresh;
  logic       is_cont;
  logic       printable;
  logic [7:0] b;
  logic       last;

  assign b         = in_data.in_byte;
  assign last      = in_data.name_last;
  assign is_cont   = (b & u8ns_pkg::CONT_MASK) == u8ns_pkg::CONT_VAL;
  assign printable = b >= u8ns_pkg::PRINT_LO && b < u8ns_pkg::PRINT_HI;
  assign len       = u8ns_pkg::lead_length(b);
  assign h         = {1'b0, held_r} + 3'd1;

  always_comb begin
    n        = 3'd0;
    chr      = u8ns_pkg::QMARK;
    held_nxt = held_r;
    exp_nxt  = exp_r;
    fresh    = 1'b1;
    if (held_r != 2'd0) begin
      if (is_cont) begin
        fresh = 1'b0;
        if (h >= exp_r) begin
          n        = 3'd1;
          held_nxt = 2'd0;
          exp_nxt  = 3'd0;
        end else if (last) begin
          n        = h;
          held_nxt = 2'd0;
          exp_nxt  = 3'd0;
        end else begin
          held_nxt = h[1:0];
        end
      end else begin
        // broken sequence: one '?' per held byte
        n        = {1'b0, held_r};
        held_nxt = 2'd0;
        exp_nxt  = 3'd0;
      end
    end
    if (fresh) begin
      if (printable) begin
        n   = n + 3'd1;
        chr = b[6:0];
      end else if (len > 3'd1 && !last) begin
        held_nxt = 2'd1;
        exp_nxt  = len;
      end else begin
        n = n + 3'd1;
      end
    end
  end

  assign run_valid    = acc && n != 3'd0;
  assign run.cnt      = n;
  assign run.chr      = chr;
  assign run.name_end = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 2'd0;
      exp_r  <= 3'd0;
    end else if (acc) begin
      held_r <= held_nxt;
      exp_r  <= exp_nxt;
    end
  end

endmodule

// ----- hdl/u8ns_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8ns_queue: run descriptor queue
// Small first-in first-out buffer between classifier and emitter.
// ----------------------------------------------------------------------------
module u8ns_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  u8ns_pkg::run_t wr_data,
  input  logic           rd,
  output u8ns_pkg::run_t head,
  output logic           q_empty,
  output logic           q_full
);

  u8ns_pkg::run_t              mem_r [u8ns_pkg::QDEPTH];
  logic [u8ns_pkg::QAW-1:0]    wp_r, rp_r;
  logic [u8ns_pkg::QAW:0]      cnt_r;

  assign head    = mem_r[rp_r];
  assign q_empty = cnt_r == '0;
  assign q_full  = cnt_r == (u8ns_pkg::QAW+1)'(u8ns_pkg::QDEPTH);

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= rp_r + 1'b1;
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/u8ns_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8ns_back: result emitter
// Expands the head run descriptor into words in the output register, one per
// cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module u8ns_back (
  input  logic                clk,
  input  logic                rst_n,
  input  u8ns_pkg::run_t      head,
  input  logic                q_empty,
  output logic                q_rd,
  input  logic                pop,
  output logic                empty,
  output u8ns_pkg::out_word_t out_data
);

  logic                out_valid_r;
  u8ns_pkg::out_word_t out_data_r;
  logic [1:0]          idx_r;
  logic                take;
  logic                emit;
  logic                is_last;

  assign take    = !out_valid_r || pop;
  assign emit    = take && !q_empty;
  assign is_last = ({1'b0, idx_r} + 3'd1) == head.cnt;
  assign q_rd    = emit && is_last;

  assign empty    = !out_valid_r;
  assign out_data = out_data_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.out_char <= is_last ? head.chr : u8ns_pkg::QMARK;
      out_data_r.run_last <= is_last;
      out_data_r.name_end <= is_last && head.name_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/utf8_name_sanitizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_name_sanitizer: folds name bytes into printable characters
// Printable ascii passes; a complete utf-8 sequence or any bad byte becomes '?'.
// ----------------------------------------------------------------------------
// one byte is taken per cycle while the four-entry run queue has room; each
// byte yields zero to four words, and the emitter sends one word per cycle
// while its output is free or popped, so a multi-word byte holds the output
// side until all its words are sent; the input stalls only once the queue fills.
module utf8_name_sanitizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  u8ns_pkg::in_word_t  in_data,
  input  logic                pop,
  output logic                empty,
  output u8ns_pkg::out_word_t out_data
);

  logic           acc;
  logic           run_valid;
  u8ns_pkg::run_t run;
  u8ns_pkg::run_t head;
  logic           q_empty;
  logic           q_full;
  logic           q_rd;

  assign full = q_full;
  assign acc  = push && !q_full;

  u8ns_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_data   (in_data),
    .run_valid (run_valid),
    .run       (run)
  );

  u8ns_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (run_valid),
    .wr_data (run),
    .rd      (q_rd),
    .head    (head),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  u8ns_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_empty  (q_empty),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule
